// ----- src/hpa_pkg.sv -----
`timescale 1ns / 1ps
package hpa_pkg;

  localparam int HUE_TURN   = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int FRAC_ONE   = 65536;

  // Configuration register indexes.
  localparam logic [2:0] REG_HUE_SHIFT   = 3'd0;
  localparam logic [2:0] REG_SAT_SHIFT   = 3'd1;
  localparam logic [2:0] REG_VAL_SHIFT   = 3'd2;
  localparam logic [2:0] REG_VAL_LEVEL   = 3'd3;
  localparam logic [2:0] REG_ADJ_MODE    = 3'd4;
  localparam logic [2:0] REG_MASK_ENABLE = 3'd5;

  // floor(2^24 / 15), used to divide by 15 with one correction step.
  localparam logic [20:0] RECIP15 = 21'd1118481;

  // Pixel data that rides along the whole pipeline.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       pass;
  } meta_t;

  // Side data that travels with the two dividers.
  typedef struct packed {
    logic [16:0] v;
    logic [14:0] base;
    logic        neg;
    logic        dz;
    logic        mz;
  } hside_t;

  // Four restoring division steps: returns {remainder, four quotient bits}.
  function automatic logic [11:0] div4(input logic [7:0] rem, input logic [3:0] nb,
                                       input logic [7:0] dv);
    logic [8:0] t;
    logic [7:0] rr;
    logic [3:0] q;
    rr = rem;
    q  = '0;
    for (int k = 3; k >= 0; k--) begin
      t = {rr, nb[k]};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[k] = 1'b1;
      end
      rr = t[7:0];
    end
    return {rr, q};
  endfunction

  // floor((x + 1) * 255 / 65536) for a fraction x in 0..65536.
  function automatic logic [7:0] to_chan(input logic [16:0] x);
    logic [17:0] y;
    logic [25:0] z;
    y = 18'(x) + 18'd1;
    z = 26'(y) * 26'd255;
    return z[23:16];
  endfunction

endpackage

// ----- src/hsv_pixel_adjust.sv -----
`timescale 1ns / 1ps
// HSV pixel adjuster: one RGBA pixel plus one mask pixel in, one RGBA pixel out.
// Input channel: in_valid with in_stall; a pixel transfers when in_valid is high
// and in_stall is low. Output channel: out_valid with out_stall, same rule.
// Configuration: a plain write port (cfg_we, cfg_index, cfg_wdata); index 0 hue
// shift, 1 saturation shift, 2 value shift, 3 value level, 4 adjust mode, 5 mask
// enable. Write registers only while no pixel is in flight.
// Throughput: one pixel per cycle unless the receiver stalls. The depth is set by
// two 24-bit restoring dividers (saturation and hue), four quotient bits per stage
// over six stages, and the back conversion multipliers, each followed by a register.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the register
// defaults: all zero except value level, which is one.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
module hsv_pixel_adjust (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_mask_red,
  input  logic [7:0]  in_mask_green,
  input  logic [7:0]  in_mask_blue,
  input  logic [7:0]  in_mask_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);
  import hpa_pkg::*;

  localparam int LAST = 14;
  localparam int DSTG = 6;

  // Configuration registers.
  logic [15:0] hue_shift_r;
  logic [17:0] sat_shift_r;
  logic [17:0] val_shift_r;
  logic [16:0] val_level_r;
  logic        adj_mode_r;
  logic        mask_en_r;

  logic            en;
  logic [LAST:0]   vld_r;
  meta_t           meta_r [0:LAST];

  // Divider stages.
  logic [23:0] snum_r [0:DSTG];
  logic [7:0]  srem_r [0:DSTG];
  logic [23:0] squo_r [0:DSTG];
  logic [7:0]  sdiv_r [0:DSTG];
  logic [23:0] hnum_r [0:DSTG];
  logic [7:0]  hrem_r [0:DSTG];
  logic [23:0] hquo_r [0:DSTG];
  logic [7:0]  hdiv_r [0:DSTG];
  hside_t      side_r [0:DSTG];
  logic [11:0] sstep  [1:DSTG];
  logic [11:0] hstep  [1:DSTG];

  // Stage 1 logic.
  logic [7:0]        mx, mn, dd, mag;
  logic signed [8:0] diff;
  logic [14:0]       base1;
  logic [19:0]       hprod;
  logic [16:0]       v1;

  // Stage 8 logic and registers.
  logic [16:0]        sq;
  logic [11:0]        hq;
  logic signed [19:0] hraw, hsh, h2, s2, v2, ssum, vsum;
  logic [14:0]        h8_r;
  logic [16:0]        s8_r, v8_r;

  // Stage 9 to 14.
  logic [14:0] hu;
  logic [2:0]  sec_nxt;
  logic [2:0]  sec9_r, sec10_r, sec11_r, sec12_r, sec13_r;
  logic [11:0] f9_r;
  logic [16:0] s9_r, v9_r, s10_r, v10_r, s11_r, v11_r, s12_r, v12_r;
  logic [28:0] p1, p2;
  logic [19:0] x1_10_r, x2_10_r, x1_11_r, x2_11_r;
  logic [40:0] e1, e2;
  logic [16:0] est1_r, est2_r;
  logic [20:0] rm1, rm2;
  logic [16:0] a1_r, a2_r;
  logic [33:0] pp, pq, pt;
  logic [16:0] p13_r, q13_r, t13_r, v13_r;
  logic        sz13_r;
  logic [16:0] rr, gg, bb;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_shift_r <= '0;
      sat_shift_r <= '0;
      val_shift_r <= '0;
      val_level_r <= 17'(FRAC_ONE);
      adj_mode_r  <= 1'b0;
      mask_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HUE_SHIFT:   hue_shift_r <= cfg_wdata[15:0];
        REG_SAT_SHIFT:   sat_shift_r <= cfg_wdata;
        REG_VAL_SHIFT:   val_shift_r <= cfg_wdata;
        REG_VAL_LEVEL:   val_level_r <= cfg_wdata[16:0];
        REG_ADJ_MODE:    adj_mode_r  <= cfg_wdata[0];
        REG_MASK_ENABLE: mask_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign en        = !(vld_r[LAST] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // Stage 0: capture the pixel and decide on mask pass-through.
  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0].r    <= in_red;
      meta_r[0].g    <= in_green;
      meta_r[0].b    <= in_blue;
      meta_r[0].a    <= in_alpha;
      meta_r[0].pass <= mask_en_r && in_mask_red == 8'd0 && in_mask_green == 8'd0 &&
                        in_mask_blue == 8'd0 && in_mask_alpha > 8'd128;
      for (int k = 1; k <= LAST; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // Stage 1: max, min, value and the two division operands.
  always_comb begin
    mx = meta_r[0].r;
    if (meta_r[0].g > mx) mx = meta_r[0].g;
    if (meta_r[0].b > mx) mx = meta_r[0].b;
    mn = meta_r[0].r;
    if (meta_r[0].g < mn) mn = meta_r[0].g;
    if (meta_r[0].b < mn) mn = meta_r[0].b;
    dd = mx - mn;
    if (mx == meta_r[0].r) begin
      diff  = $signed({1'b0, meta_r[0].g}) - $signed({1'b0, meta_r[0].b});
      base1 = 15'd0;
    end else if (mx == meta_r[0].g) begin
      diff  = $signed({1'b0, meta_r[0].b}) - $signed({1'b0, meta_r[0].r});
      base1 = 15'(2 * HUE_SECTOR);
    end else begin
      diff  = $signed({1'b0, meta_r[0].r}) - $signed({1'b0, meta_r[0].g});
      base1 = 15'(4 * HUE_SECTOR);
    end
    mag   = diff[8] ? 8'(-diff) : diff[7:0];
    hprod = 20'(mag) * 20'(HUE_SECTOR);
    // mx * 65536 / 255 = mx * 257 + (mx == 255).
    v1    = {1'b0, mx, 8'd0} + 17'(mx) + 17'(mx == 8'hFF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum_r[0]      <= {dd, 16'd0};
      srem_r[0]      <= '0;
      squo_r[0]      <= '0;
      sdiv_r[0]      <= mx;
      hnum_r[0]      <= {4'd0, hprod};
      hrem_r[0]      <= '0;
      hquo_r[0]      <= '0;
      hdiv_r[0]      <= dd;
      side_r[0].v    <= v1;
      side_r[0].base <= base1;
      side_r[0].neg  <= diff[8];
      side_r[0].dz   <= dd == 8'd0;
      side_r[0].mz   <= mx == 8'd0;
    end
  end

  // Stages 2 to 7: both dividers, four quotient bits per stage.
  always_comb begin
    for (int j = 1; j <= DSTG; j++) begin
      sstep[j] = div4(srem_r[j-1], snum_r[j-1][23:20], sdiv_r[j-1]);
      hstep[j] = div4(hrem_r[j-1], hnum_r[j-1][23:20], hdiv_r[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= DSTG; j++) begin
        snum_r[j] <= {snum_r[j-1][19:0], 4'd0};
        srem_r[j] <= sstep[j][11:4];
        squo_r[j] <= {squo_r[j-1][19:0], sstep[j][3:0]};
        sdiv_r[j] <= sdiv_r[j-1];
        hnum_r[j] <= {hnum_r[j-1][19:0], 4'd0};
        hrem_r[j] <= hstep[j][11:4];
        hquo_r[j] <= {hquo_r[j-1][19:0], hstep[j][3:0]};
        hdiv_r[j] <= hdiv_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // Stage 8: finish hue, then apply the shifts or the value level.
  always_comb begin
    sq   = side_r[DSTG].mz ? 17'd0 : squo_r[DSTG][16:0];
    hq   = side_r[DSTG].dz ? 12'd0 : hquo_r[DSTG][11:0];
    hraw = side_r[DSTG].neg ? $signed(20'(side_r[DSTG].base)) - $signed(20'(hq))
                            : $signed(20'(side_r[DSTG].base)) + $signed(20'(hq));
    if (hraw < 20'sd0) hraw = hraw + 20'sd23040;
    hsh = 20'(signed'(hue_shift_r));
    if (hsh > 20'sd23040)  hsh = 20'sd23040;
    if (hsh < -20'sd23040) hsh = -20'sd23040;
    ssum = $signed(20'(sq)) + 20'(signed'(sat_shift_r));
    vsum = $signed(20'(side_r[DSTG].v)) + 20'(signed'(val_shift_r));
    if (!adj_mode_r) begin
      h2 = hraw + hsh;
      if (h2 > 20'sd23040) h2 = h2 - 20'sd23040;
      if (h2 < 20'sd0)     h2 = h2 + 20'sd23040;
      s2 = ssum;
      if (s2 < 20'sd0)     s2 = 20'sd0;
      if (s2 > 20'sd65536) s2 = 20'sd65536;
      v2 = vsum;
      if (v2 < 20'sd0)     v2 = 20'sd0;
      if (v2 > 20'sd65536) v2 = 20'sd65536;
    end else begin
      h2 = hraw;
      s2 = $signed(20'(sq));
      v2 = (val_level_r > 17'(FRAC_ONE)) ? 20'sd65536 : $signed(20'(val_level_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h8_r <= h2[14:0];
      s8_r <= s2[16:0];
      v8_r <= v2[16:0];
    end
  end

  // Stage 9: sector and position inside it.
  always_comb begin
    hu = (h8_r >= 15'(HUE_TURN)) ? 15'd0 : h8_r;
    if (hu >= 15'(5 * HUE_SECTOR))      sec_nxt = 3'd5;
    else if (hu >= 15'(4 * HUE_SECTOR)) sec_nxt = 3'd4;
    else if (hu >= 15'(3 * HUE_SECTOR)) sec_nxt = 3'd3;
    else if (hu >= 15'(2 * HUE_SECTOR)) sec_nxt = 3'd2;
    else if (hu >= 15'(HUE_SECTOR))     sec_nxt = 3'd1;
    else                                sec_nxt = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec9_r <= sec_nxt;
      f9_r   <= 12'(hu - 15'(sec_nxt) * 15'(HUE_SECTOR));
      s9_r   <= s8_r;
      v9_r   <= v8_r;
    end
  end

  // Stage 10: S*f and S*(3840-f), divided by 256.
  assign p1 = 29'(s9_r) * 29'(f9_r);
  assign p2 = 29'(s9_r) * 29'(12'(HUE_SECTOR) - f9_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_10_r <= p1[27:8];
      x2_10_r <= p2[27:8];
      sec10_r <= sec9_r;
      s10_r   <= s9_r;
      v10_r   <= v9_r;
    end
  end

  // Stage 11: estimate of x / 15 through the reciprocal.
  assign e1 = 41'(x1_10_r) * 41'(RECIP15);
  assign e2 = 41'(x2_10_r) * 41'(RECIP15);

  always_ff @(posedge clk) begin
    if (en) begin
      est1_r  <= e1[40:24];
      est2_r  <= e2[40:24];
      x1_11_r <= x1_10_r;
      x2_11_r <= x2_10_r;
      sec11_r <= sec10_r;
      s11_r   <= s10_r;
      v11_r   <= v10_r;
    end
  end

  // Stage 12: the estimate is low by at most one.
  assign rm1 = 21'(x1_11_r) - 21'(est1_r) * 21'd15;
  assign rm2 = 21'(x2_11_r) - 21'(est2_r) * 21'd15;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= (rm1 >= 21'd15) ? est1_r + 17'd1 : est1_r;
      a2_r    <= (rm2 >= 21'd15) ? est2_r + 17'd1 : est2_r;
      sec12_r <= sec11_r;
      s12_r   <= s11_r;
      v12_r   <= v11_r;
    end
  end

  // Stage 13: p, q and t.
  assign pp = 34'(v12_r) * 34'(17'(FRAC_ONE) - s12_r);
  assign pq = 34'(v12_r) * 34'(17'(FRAC_ONE) - a1_r);
  assign pt = 34'(v12_r) * 34'(17'(FRAC_ONE) - a2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p13_r   <= pp[32:16];
      q13_r   <= pq[32:16];
      t13_r   <= pt[32:16];
      v13_r   <= v12_r;
      sec13_r <= sec12_r;
      sz13_r  <= s12_r == 17'd0;
    end
  end

  // Stage 14: sector mapping and conversion to 8-bit channels.
  always_comb begin
    case (sec13_r)
      3'd0:    begin rr = v13_r; gg = t13_r; bb = p13_r; end
      3'd1:    begin rr = q13_r; gg = v13_r; bb = p13_r; end
      3'd2:    begin rr = p13_r; gg = v13_r; bb = t13_r; end
      3'd3:    begin rr = p13_r; gg = q13_r; bb = v13_r; end
      3'd4:    begin rr = t13_r; gg = p13_r; bb = v13_r; end
      default: begin rr = v13_r; gg = p13_r; bb = q13_r; end
    endcase
    if (sz13_r) begin
      rr = v13_r;
      gg = v13_r;
      bb = v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (meta_r[LAST-1].pass) begin
        out_red_r   <= meta_r[LAST-1].r;
        out_green_r <= meta_r[LAST-1].g;
        out_blue_r  <= meta_r[LAST-1].b;
      end else begin
        out_red_r   <= to_chan(rr);
        out_green_r <= to_chan(gg);
        out_blue_r  <= to_chan(bb);
      end
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = meta_r[LAST].a;

  // An accepted transfer always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted pixel missing from first stage");

  // A held result freezes every stage.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  // The adjusted hue stays within one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (h8_r <= 15'(HUE_TURN)))
    else $error("hue out of range after adjustment");

  // The scaled saturation terms never exceed one.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[12] |-> (a1_r <= 17'(FRAC_ONE) && a2_r <= 17'(FRAC_ONE)))
    else $error("scaled saturation term above one");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import hpa_pkg::*;

  localparam bit MODE_SHIFT = 1'b0;
  localparam bit MODE_LEVEL = 1'b1;
  localparam int PIPE_DEPTH = 15;

  typedef struct {
    logic [7:0] r, g, b, a, mr, mg, mb, ma;
  } pixel_t;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic [7:0]  in_mask_red = '0, in_mask_green = '0, in_mask_blue = '0, in_mask_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;

  // Local copy of the adjuster's register file.
  logic signed [15:0] hue_adj = '0;
  logic signed [17:0] sat_offset = '0;
  logic signed [17:0] val_offset = '0;
  logic [16:0]        val_level = 17'd65536;
  logic               adj_mode = MODE_SHIFT;
  logic               mask_on = 1'b0;

  pixel_t pending_pixels[$];
  rgba_t  expected_pixels[$];
  pixel_t drv_pixel;
  int     gap_left = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;
  int     errors = 0;

  hsv_pixel_adjust dut (.*);

  always #10 clk = ~clk;

  function automatic int clamp_int(int x, int lo, int hi);
    return (x < lo) ? lo : (x > hi) ? hi : x;
  endfunction

  function automatic logic [7:0] frac_to_chan(longint x);
    longint y;
    y = ((x + 1) * 255) >>> 16;
    return y[7:0];
  endfunction

  // Expected output pixel for one input pixel under the current registers.
  function automatic rgba_t adjust_pixel(pixel_t p);
    rgba_t  res;
    int     r, g, b, mx, mn, d, h, s, v, hu, sec, f;
    longint vv, ss, pp, qq, tt;
    longint ch_r, ch_g, ch_b;
    res.a = p.a;
    if (mask_on && p.mr == 0 && p.mg == 0 && p.mb == 0 && p.ma > 128) begin
      res.r = p.r;
      res.g = p.g;
      res.b = p.b;
      return res;
    end
    r = p.r;
    g = p.g;
    b = p.b;
    mx = (r > g) ? r : g;
    mx = (b > mx) ? b : mx;
    mn = (r < g) ? r : g;
    mn = (b < mn) ? b : mn;
    d = mx - mn;
    v = (mx * FRAC_ONE) / 255;
    s = (mx != 0) ? (d * FRAC_ONE) / mx : 0;
    if (d == 0) h = 0;
    else if (mx == r) h = (HUE_SECTOR * (g - b)) / d;
    else if (mx == g) h = 2 * HUE_SECTOR + (HUE_SECTOR * (b - r)) / d;
    else h = 4 * HUE_SECTOR + (HUE_SECTOR * (r - g)) / d;
    if (h < 0) h += HUE_TURN;

    if (adj_mode == MODE_SHIFT) begin
      h += clamp_int(int'(hue_adj), -HUE_TURN, HUE_TURN);
      if (h > HUE_TURN) h -= HUE_TURN;
      if (h < 0) h += HUE_TURN;
      s = clamp_int(s + int'(sat_offset), 0, FRAC_ONE);
      v = clamp_int(v + int'(val_offset), 0, FRAC_ONE);
    end else begin
      v = (val_level > FRAC_ONE) ? FRAC_ONE : int'(val_level);
    end

    if (s == 0) begin
      ch_r = v;
      ch_g = v;
      ch_b = v;
    end else begin
      hu = (h >= HUE_TURN) ? 0 : h;
      sec = hu / HUE_SECTOR;
      f = hu % HUE_SECTOR;
      vv = v;
      ss = s;
      pp = (vv * (FRAC_ONE - ss)) >>> 16;
      qq = (vv * (FRAC_ONE - (ss * f) / HUE_SECTOR)) >>> 16;
      tt = (vv * (FRAC_ONE - (ss * (HUE_SECTOR - f)) / HUE_SECTOR)) >>> 16;
      case (sec)
        0: begin ch_r = vv; ch_g = tt; ch_b = pp; end
        1: begin ch_r = qq; ch_g = vv; ch_b = pp; end
        2: begin ch_r = pp; ch_g = vv; ch_b = tt; end
        3: begin ch_r = pp; ch_g = qq; ch_b = vv; end
        4: begin ch_r = tt; ch_g = pp; ch_b = vv; end
        default: begin ch_r = vv; ch_g = pp; ch_b = qq; end
      endcase
    end
    res.r = frac_to_chan(ch_r);
    res.g = frac_to_chan(ch_g);
    res.b = frac_to_chan(ch_b);
    return res;
  endfunction

  // Input driver: holds a stalled pixel, otherwise idles in bursts or sends the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_pixels.push_back(adjust_pixel(drv_pixel));
      if (in_valid && in_stall) begin
        // Payload stays put until the transfer happens.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        drv_pixel = pending_pixels.pop_front();
        in_red <= drv_pixel.r;
        in_green <= drv_pixel.g;
        in_blue <= drv_pixel.b;
        in_alpha <= drv_pixel.a;
        in_mask_red <= drv_pixel.mr;
        in_mask_green <= drv_pixel.mg;
        in_mask_blue <= drv_pixel.mb;
        in_mask_alpha <= drv_pixel.ma;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each transfer against the oldest expected pixel.
  always @(posedge clk) begin
    rgba_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output pixel r=%0d g=%0d b=%0d a=%0d",
               out_red, out_green, out_blue, out_alpha);
        errors++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_red !== exp_px.r) begin
          $error("out_red expected %0d actual %0d", exp_px.r, out_red);
          errors++;
        end
        if (out_green !== exp_px.g) begin
          $error("out_green expected %0d actual %0d", exp_px.g, out_green);
          errors++;
        end
        if (out_blue !== exp_px.b) begin
          $error("out_blue expected %0d actual %0d", exp_px.b, out_blue);
          errors++;
        end
        if (out_alpha !== exp_px.a) begin
          $error("out_alpha expected %0d actual %0d", exp_px.a, out_alpha);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cfg_write(logic [2:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 18'(value);
    case (idx)
      REG_HUE_SHIFT:   hue_adj = 16'(value);
      REG_SAT_SHIFT:   sat_offset = 18'(value);
      REG_VAL_SHIFT:   val_offset = 18'(value);
      REG_VAL_LEVEL:   val_level = 17'(value);
      REG_ADJ_MODE:    adj_mode = value[0];
      REG_MASK_ENABLE: mask_on = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(int hs, int ss, int vs, int lvl, int mode, int msk);
    cfg_write(REG_HUE_SHIFT, hs);
    cfg_write(REG_SAT_SHIFT, ss);
    cfg_write(REG_VAL_SHIFT, vs);
    cfg_write(REG_VAL_LEVEL, lvl);
    cfg_write(REG_ADJ_MODE, mode);
    cfg_write(REG_MASK_ENABLE, msk);
  endtask

  function automatic pixel_t make_pixel(int r, int g, int b, int a,
                                        int mr, int mg, int mb, int ma);
    pixel_t p;
    p.r = r; p.g = g; p.b = b; p.a = a;
    p.mr = mr; p.mg = mg; p.mb = mb; p.ma = ma;
    return p;
  endfunction

  // Random pixel, biased toward grays, tied maxima and black mask pixels.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = make_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: begin p.g = p.r; p.b = p.r; end
      1: p.g = p.r;
      2: p.b = p.g;
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      p.mr = 0; p.mg = 0; p.mb = 0;
      if ($urandom_range(0, 1) == 0) p.ma = $urandom_range(126, 131);
    end
    return p;
  endfunction

  task automatic send_random(int n);
    repeat (n) pending_pixels.push_back(rand_pixel());
  endtask

  // Wait until every pixel has come back, then let the pipeline drain.
  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: extremes, primaries, grays and tied maxima.
    pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 255));
    pending_pixels.push_back(make_pixel(255, 255, 255, 255, 255, 255, 255, 0));
    pending_pixels.push_back(make_pixel(255, 0, 0, 1, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(0, 255, 0, 128, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(0, 0, 255, 254, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 0, 7, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(0, 255, 255, 9, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 0, 255, 11, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(128, 128, 128, 33, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(1, 0, 0, 44, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 0, 1, 55, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(200, 17, 90, 66, 0, 0, 0, 0));
    send_random(40);
    drain();

    // Full-turn hue, saturation to one, value to zero, masking on.
    cfg_all(HUE_TURN, FRAC_ONE, -FRAC_ONE, 0, MODE_SHIFT, 1);
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 0, 0, 0, 129));
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 0, 0, 0, 128));
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 0, 0, 0, 255));
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 1, 0, 0, 255));
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 0, 1, 0, 255));
    pending_pixels.push_back(make_pixel(10, 200, 30, 77, 0, 0, 1, 255));
    send_random(50);
    drain();

    cfg_all(-HUE_TURN, -FRAC_ONE, FRAC_ONE, 0, MODE_SHIFT, 0);
    send_random(60);
    drain();

    // Hue offsets beyond one turn, value level above one, set-value mode with mask.
    cfg_all(-32768, 12345, -4321, 131071, MODE_LEVEL, 1);
    send_random(60);
    drain();

    cfg_all(32767, -FRAC_ONE, 0, FRAC_ONE, MODE_LEVEL, 0);
    cfg_write(3'd6, 18'h3FFFF);
    cfg_write(3'd7, 18'h2AAAA);
    send_random(60);
    drain();

    cfg_all(0, 0, 0, 0, MODE_LEVEL, 0);
    send_random(60);
    drain();

    cfg_all(1920, 20000, -20000, 30000, MODE_SHIFT, 1);
    send_random(60);
    drain();

    // Random register settings over the full write width.
    repeat (2) begin
      cfg_all($urandom_range(0, 65535), $urandom_range(0, 262143), $urandom_range(0, 262143),
              $urandom_range(0, 131071), $urandom_range(0, 1), $urandom_range(0, 1));
      send_random(60);
      drain();
    end

    // Closing stretch without idling on either side.
    calm = 1'b1;
    cfg_all($urandom_range(0, 65535), $urandom_range(0, 262143), $urandom_range(0, 262143),
            $urandom_range(0, 131071), MODE_SHIFT, 1);
    send_random(60);
    drain();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
